// ===== hw/rtl/bpid_pkg.sv =====
package bpid_pkg;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] REG_TARGET_ANGLE = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_ANGLE_GAIN_P = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_ANGLE_GAIN_I = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_GYRO_GAIN_D  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_SPEED_GAIN_P = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_SPEED_GAIN_I = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_DUTY_LIMIT   = 3'd6;

   localparam logic signed [16:0] TARGET_ANGLE_RST = 17'sd154;
   localparam logic signed [31:0] ANGLE_GAIN_P_RST = 32'sd117964800;
   localparam logic signed [31:0] ANGLE_GAIN_I_RST = 32'sd196608;
   localparam logic signed [31:0] GYRO_GAIN_D_RST  = -32'sd1638400;
   localparam logic signed [31:0] SPEED_GAIN_P_RST = -32'sd1114112;
   localparam logic signed [31:0] SPEED_GAIN_I_RST = -32'sd3277;
   localparam logic [14:0]        DUTY_LIMIT_RST   = 15'd8000;

   // Error clamp and tip threshold, degrees Q.8 (10 and 7 degrees).
   localparam logic signed [17:0] ERR_CLAMP = 18'sd2560;
   localparam logic signed [12:0] ERR_MAX   = 13'sd2560;
   localparam logic signed [12:0] TIP_LEVEL = 13'sd1792;

   localparam logic [5:0] ANGLE_SHIFT = 6'd24;
   localparam logic [5:0] SPEED_SHIFT = 6'd16;

   typedef struct packed {
      logic signed [16:0] target_angle;
      logic signed [31:0] angle_gain_p;
      logic signed [31:0] angle_gain_i;
      logic signed [31:0] gyro_gain_d;
      logic signed [31:0] speed_gain_p;
      logic signed [31:0] speed_gain_i;
      logic [14:0]        duty_limit;
   } cfg_type;

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s;
   endfunction

   function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [63:0] d;
      d = a - b;
      if (a[63] != b[63] && d[63] != a[63]) begin
         d = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return d;
   endfunction

   // Divide by 2^sh rounding toward zero, then saturate to 16 bits.
   function automatic logic signed [15:0] trunc_sat16(input logic signed [63:0] x,
                                                      input logic [5:0] sh);
      logic signed [63:0] bias;
      logic signed [63:0] q;
      logic signed [15:0] r;
      bias = x[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
      q = (x + bias) >>> sh;
      if (q > 64'sd32767) begin
         r = 16'sh7fff;
      end else if (q < -64'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = q[15:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/bpid_pipe.sv =====
module bpid_pipe import bpid_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic signed [16:0] in_pitch,
   input  logic signed [15:0] in_gyro,
   input  logic signed [15:0] in_speed,
   input  cfg_type            cfg,
   output logic               out_valid,
   output logic signed [15:0] out_duty,
   output logic               out_tipped
);

   // Stage 1: input register.
   logic               v1_ff;
   logic signed [16:0] pitch_ff;
   logic signed [15:0] gyro_ff;
   logic signed [15:0] speed_ff;

   // Stage 2: clamped error and products.
   logic               v2_ff;
   logic               tip2_ff, tip2_in;
   logic signed [44:0] err_kp2_ff, err_kp2_in;
   logic signed [44:0] err_ki2_ff, err_ki2_in;
   logic signed [47:0] gyro_kd2_ff, gyro_kd2_in;
   logic signed [47:0] spd_kp2_ff, spd_kp2_in;
   logic signed [47:0] spd_ki2_ff, spd_ki2_in;

   // Integrators, updated as an item leaves stage 2.
   logic signed [63:0] angle_integral_ff, angle_integral_in;
   logic signed [63:0] speed_integral_ff, speed_integral_in;

   // Stage 3: products waiting for the integrators.
   logic               v3_ff;
   logic               tip3_ff;
   logic signed [44:0] err_kp3_ff;
   logic signed [47:0] gyro_kd3_ff;
   logic signed [47:0] spd_kp3_ff;

   // Stage 4: angle P plus I, speed term.
   logic               v4_ff;
   logic               tip4_ff;
   logic signed [63:0] acc4_ff, acc4_in;
   logic signed [63:0] spd4_ff, spd4_in;
   logic signed [47:0] gyro_kd4_ff;

   // Stage 5: full angle sum.
   logic               v5_ff;
   logic               tip5_ff;
   logic signed [63:0] acc5_ff, acc5_in;
   logic signed [63:0] spd5_ff;

   // Stage 6: angle duty.
   logic               v6_ff;
   logic               tip6_ff;
   logic signed [15:0] duty6_ff, duty6_in;
   logic signed [63:0] spd6_ff;

   // Stage 7: angle duty minus speed term.
   logic               v7_ff;
   logic               tip7_ff;
   logic signed [63:0] acc7_ff, acc7_in;

   // Result register.
   logic               out_valid_ff;
   logic signed [15:0] out_duty_ff, out_duty_in;
   logic               out_tipped_ff;

   logic signed [17:0] err_raw;
   logic signed [12:0] err_q;
   logic signed [15:0] duty_q;
   logic signed [16:0] lim_pos;
   logic signed [16:0] lim_neg;

   always_comb begin
      err_raw = 18'(pitch_ff) - 18'(cfg.target_angle);
      priority if (err_raw >= ERR_CLAMP) begin
         err_q = ERR_MAX;
      end else if (err_raw <= -ERR_CLAMP) begin
         err_q = -ERR_MAX;
      end else begin
         err_q = err_raw[12:0];
      end
      tip2_in     = (err_q >= TIP_LEVEL) || (err_q <= -TIP_LEVEL);
      err_kp2_in  = 45'(err_q) * 45'(cfg.angle_gain_p);
      err_ki2_in  = 45'(err_q) * 45'(cfg.angle_gain_i);
      gyro_kd2_in = 48'(gyro_ff) * 48'(cfg.gyro_gain_d);
      spd_kp2_in  = 48'(speed_ff) * 48'(cfg.speed_gain_p);
      spd_ki2_in  = 48'(speed_ff) * 48'(cfg.speed_gain_i);
   end

   assign angle_integral_in = sat_add64(angle_integral_ff, 64'(err_ki2_ff));
   assign speed_integral_in = sat_add64(speed_integral_ff, 64'(spd_ki2_ff));

   // Stage 3 reads the integrators right after its own item updated them.
   assign acc4_in  = sat_add64(64'(err_kp3_ff), angle_integral_ff);
   assign spd4_in  = sat_add64(64'(spd_kp3_ff), speed_integral_ff);
   assign acc5_in  = sat_add64(acc4_ff, 64'(gyro_kd4_ff) <<< 8);
   assign duty6_in = trunc_sat16(acc5_ff, ANGLE_SHIFT);
   assign acc7_in  = sat_sub64(64'(duty6_ff) <<< 16, spd6_ff);

   always_comb begin
      duty_q  = trunc_sat16(acc7_ff, SPEED_SHIFT);
      lim_pos = 17'(cfg.duty_limit);
      lim_neg = -lim_pos;
      if (17'(duty_q) > lim_pos) begin
         duty_q = lim_pos[15:0];
      end
      if (17'(duty_q) < lim_neg) begin
         duty_q = lim_neg[15:0];
      end
      out_duty_in = tip7_ff ? 16'sd0 : duty_q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff             <= 1'b0;
         v2_ff             <= 1'b0;
         v3_ff             <= 1'b0;
         v4_ff             <= 1'b0;
         v5_ff             <= 1'b0;
         v6_ff             <= 1'b0;
         v7_ff             <= 1'b0;
         out_valid_ff      <= 1'b0;
         angle_integral_ff <= '0;
         speed_integral_ff <= '0;
      end else if (advance) begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         out_valid_ff <= v7_ff;
         if (v2_ff) begin
            angle_integral_ff <= angle_integral_in;
            speed_integral_ff <= speed_integral_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pitch_ff      <= in_pitch;
         gyro_ff       <= in_gyro;
         speed_ff      <= in_speed;
         tip2_ff       <= tip2_in;
         err_kp2_ff    <= err_kp2_in;
         err_ki2_ff    <= err_ki2_in;
         gyro_kd2_ff   <= gyro_kd2_in;
         spd_kp2_ff    <= spd_kp2_in;
         spd_ki2_ff    <= spd_ki2_in;
         tip3_ff       <= tip2_ff;
         err_kp3_ff    <= err_kp2_ff;
         gyro_kd3_ff   <= gyro_kd2_ff;
         spd_kp3_ff    <= spd_kp2_ff;
         tip4_ff       <= tip3_ff;
         acc4_ff       <= acc4_in;
         spd4_ff       <= spd4_in;
         gyro_kd4_ff   <= gyro_kd3_ff;
         tip5_ff       <= tip4_ff;
         acc5_ff       <= acc5_in;
         spd5_ff       <= spd4_ff;
         tip6_ff       <= tip5_ff;
         duty6_ff      <= duty6_in;
         spd6_ff       <= spd5_ff;
         tip7_ff       <= tip6_ff;
         acc7_ff       <= acc7_in;
         out_duty_ff   <= out_duty_in;
         out_tipped_ff <= tip7_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_duty   = out_duty_ff;
   assign out_tipped = out_tipped_ff;

   // A stalled pipeline must not integrate anything.
   a_stall_holds_integrators: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(angle_integral_ff) && $stable(speed_integral_ff))
      else $error("integrator moved during a stall");

   // Integrators only move when an item leaves stage 2; this checks the angle integrator.
   a_integrate_only_on_item: assert property (@(posedge clock) disable iff (reset)
      !(advance && v2_ff) |=> $stable(angle_integral_ff))
      else $error("angle integrator moved without an item");

endmodule

// ===== hw/rtl/balance_pid_with_speed_loop.sv =====
// Cascaded balance controller: an angle PID with a wheel-speed PI loop subtracted.
// Input beats on req_* carry one sensor sample (pitch angle, gyro rate, wheel speed);
// each produces exactly one result beat on rsp_* with the drive duty in tdata and
// the tip flag in tuser.
// Gains, target angle and duty limit are written through csr_we/csr_addr/csr_wdata;
// the user must write them only while no sample is in flight; the block does not
// enforce this. Writes to unused indexes are dropped.
// Throughput: one sample per cycle while the output is not stalled; the datapath is
// a seven-stage pipeline. The five products are formed side by side in stage 2,
// every later stage holds at most one 64-bit saturating add on any path, and the two
// integrators each take one saturating add per sample as it leaves stage 2.
// When rsp_tready is low while a result waits, the whole pipeline holds and
// req_tready drops in the same cycle; no beat is lost or repeated.
// Reset clears the pipeline, both integrators and loads the default gains.
module balance_pid_with_speed_loop import bpid_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [16:0] pitch_angle, [32:17] gyro_rate, [48:33] wheel_speed, [55:49] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [15:0] drive_duty
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] tipped
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type            cfg_ff;
   logic               advance;
   logic signed [15:0] duty;
   logic               tipped;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_angle <= TARGET_ANGLE_RST;
         cfg_ff.angle_gain_p <= ANGLE_GAIN_P_RST;
         cfg_ff.angle_gain_i <= ANGLE_GAIN_I_RST;
         cfg_ff.gyro_gain_d  <= GYRO_GAIN_D_RST;
         cfg_ff.speed_gain_p <= SPEED_GAIN_P_RST;
         cfg_ff.speed_gain_i <= SPEED_GAIN_I_RST;
         cfg_ff.duty_limit   <= DUTY_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_TARGET_ANGLE: cfg_ff.target_angle <= csr_wdata[16:0];
            REG_ANGLE_GAIN_P: cfg_ff.angle_gain_p <= csr_wdata;
            REG_ANGLE_GAIN_I: cfg_ff.angle_gain_i <= csr_wdata;
            REG_GYRO_GAIN_D:  cfg_ff.gyro_gain_d  <= csr_wdata;
            REG_SPEED_GAIN_P: cfg_ff.speed_gain_p <= csr_wdata;
            REG_SPEED_GAIN_I: cfg_ff.speed_gain_i <= csr_wdata;
            REG_DUTY_LIMIT:   cfg_ff.duty_limit   <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   bpid_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_tvalid),
      .in_pitch   (req_tdata[16:0]),
      .in_gyro    (req_tdata[32:17]),
      .in_speed   (req_tdata[48:33]),
      .cfg        (cfg_ff),
      .out_valid  (rsp_tvalid),
      .out_duty   (duty),
      .out_tipped (tipped)
   );

   assign rsp_tdata = duty;
   assign rsp_tuser = tipped;

   a_tip_forces_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("tipped result with nonzero duty");

   a_duty_within_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata) <= $signed({2'b00, cfg_ff.duty_limit}))
                  && ($signed(rsp_tdata) >= -$signed({2'b00, cfg_ff.duty_limit})))
      else $error("duty beyond limit");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");

endmodule

// ===== tb/tb_balance_pid_with_speed_loop.sv =====
module tb_balance_pid_with_speed_loop;
   import bpid_pkg::*;

   // Index past the last register; writes to it must be dropped.
   localparam logic [CSR_ADDR_W-1:0] REG_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int DRAIN_CYCLES = 20;
   localparam int LONG_HOLD = 80;
   localparam int MAX_REPORTS = 40;
   localparam int PHASE_ITEMS = 150;
   localparam int RAIL_ITEMS = 100;

   typedef struct {
      logic [16:0] pitch;
      logic [15:0] gyro;
      logic [15:0] speed;
      int unsigned gap;
   } sample_type;

   typedef struct {
      logic [15:0] duty;
      logic        tipped;
   } duty_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   balance_pid_with_speed_loop dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Our own copy of the controller settings and integrators.
   logic signed [16:0] target_q8 = TARGET_ANGLE_RST;
   logic signed [31:0] kp_angle = ANGLE_GAIN_P_RST;
   logic signed [31:0] ki_angle = ANGLE_GAIN_I_RST;
   logic signed [31:0] kd_gyro = GYRO_GAIN_D_RST;
   logic signed [31:0] kp_speed = SPEED_GAIN_P_RST;
   logic signed [31:0] ki_speed = SPEED_GAIN_I_RST;
   logic [14:0]        duty_cap = DUTY_LIMIT_RST;
   logic signed [63:0] angle_integ = '0;
   logic signed [63:0] speed_integ = '0;

   sample_type sample_queue[$];
   duty_type   duty_expected[$];
   sample_type drv_item;
   duty_type   want;
   int unsigned gap_left = 0;
   int samples_queued = 0;
   int samples_taken = 0;
   int fault_count = 0;
   int cycle_count = 0;
   bit tx_idle_on = 1'b0;
   bit rsp_idle_on = 1'b0;
   int hold_ticket = 0;
   int hold_served = 0;
   int hold_left = 0;
   int stall_left = 0;

   function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] clip16(input logic signed [63:0] x);
      if (x > 64'sd32767) return 64'sd32767;
      if (x < -64'sd32768) return -64'sd32768;
      return x;
   endfunction

   // One control tick: updates both integrators and returns the drive command.
   function automatic duty_type balance_step(input logic [16:0] pitch,
                                             input logic [15:0] gyro,
                                             input logic [15:0] speed);
      logic signed [63:0] err, gv, sv, acc, duty, spd_term, lim;
      duty_type r;
      gv = $signed(gyro);
      sv = $signed(speed);
      err = $signed(pitch);
      err = err - target_q8;
      if (err >= ERR_MAX) err = ERR_MAX;
      else if (err <= -ERR_MAX) err = -ERR_MAX;

      angle_integ = add_sat(angle_integ, err * ki_angle);
      acc = add_sat(err * kp_angle, angle_integ);
      acc = add_sat(acc, gv * kd_gyro * 64'sd256);
      duty = clip16(acc / 64'sd16777216);

      speed_integ = add_sat(speed_integ, sv * ki_speed);
      spd_term = add_sat(sv * kp_speed, speed_integ);
      acc = sub_sat(duty * 64'sd65536, spd_term);
      duty = clip16(acc / 64'sd65536);

      lim = {49'd0, duty_cap};
      if (duty > lim) duty = lim;
      if (duty < -lim) duty = -lim;

      r.tipped = (err >= TIP_LEVEL) || (err <= -TIP_LEVEL);
      r.duty = r.tipped ? 16'd0 : duty[15:0];
      return r;
   endfunction

   function automatic bit count_fault();
      fault_count++;
      return fault_count <= MAX_REPORTS;
   endfunction

   // Sender: each queued sample may carry a number of idle cycles to insert before it.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (sample_queue.size() != 0 && sample_queue[0].gap != 0) begin
            gap_left = sample_queue[0].gap - 1;
            sample_queue[0].gap = 0;
            req_tvalid <= 1'b0;
         end else if (sample_queue.size() != 0) begin
            drv_item = sample_queue.pop_front();
            req_tdata <= {7'd0, drv_item.speed, drv_item.gyro, drv_item.pitch};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: short random stalls, plus a long hold whenever one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_ticket) begin
         hold_served = hold_ticket;
         hold_left = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 4) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Prediction happens before the check so that even a result in the same cycle as its input beat would match.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            duty_expected.push_back(balance_step(req_tdata[16:0], req_tdata[32:17],
                                                 req_tdata[48:33]));
            samples_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (duty_expected.size() == 0) begin
               if (count_fault())
                  $display("%0t: result beat with nothing expected, duty %0d tipped %0b",
                           $time, $signed(rsp_tdata), rsp_tuser);
            end else begin
               want = duty_expected.pop_front();
               if (rsp_tdata !== want.duty && count_fault())
                  $display("%0t: drive_duty expected %0d, actual %0d", $time,
                           $signed(want.duty), $signed(rsp_tdata));
               if (rsp_tuser !== want.tipped && count_fault())
                  $display("%0t: tipped expected %0b, actual %0b", $time,
                           want.tipped, rsp_tuser);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_balance_pid_with_speed_loop: FAIL");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      case (idx)
         REG_TARGET_ANGLE: target_q8 = value[16:0];
         REG_ANGLE_GAIN_P: kp_angle = value;
         REG_ANGLE_GAIN_I: ki_angle = value;
         REG_GYRO_GAIN_D:  kd_gyro = value;
         REG_SPEED_GAIN_P: kp_speed = value;
         REG_SPEED_GAIN_I: ki_speed = value;
         REG_DUTY_LIMIT:   duty_cap = value[14:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (samples_taken != samples_queued || duty_expected.size() != 0);
   endtask

   task automatic queue_sample(input int pitch, input int gyro, input int speed);
      sample_type s;
      s.pitch = pitch[16:0];
      s.gyro = gyro[15:0];
      s.speed = speed[15:0];
      s.gap = (tx_idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
      sample_queue.push_back(s);
      samples_queued++;
   endtask

   function automatic int near_target_pitch();
      int sgn;
      sgn = $urandom_range(0, 1) ? 1 : -1;
      case ($urandom_range(0, 9))
         0, 1:    return int'(target_q8) + sgn * (1790 + int'($urandom_range(0, 4)));
         2:       return int'($urandom_range(0, 131071));
         default: return int'(target_q8) + int'($urandom_range(0, 6000)) - 3000;
      endcase
   endfunction

   function automatic int sensor_value();
      if ($urandom_range(0, 4) < 3) return int'($urandom_range(0, 65535)) - 32768;
      return int'($urandom_range(0, 400)) - 200;
   endfunction

   task automatic queue_random_sample();
      queue_sample(near_target_pitch(), sensor_value(), sensor_value());
   endtask

   function automatic logic [31:0] pick_gain();
      logic [31:0] mag;
      int k;
      case ($urandom_range(0, 7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return $urandom();
         3: return 32'd0;
         default: begin
            k = $urandom_range(8, 28);
            mag = $urandom() & ((32'd1 << k) - 32'd1);
            return $urandom_range(0, 1) ? -mag : mag;
         end
      endcase
   endfunction

   // Bits above the register width are filled with junk; the block must ignore them.
   function automatic logic [31:0] pick_target();
      logic [16:0] t;
      case ($urandom_range(0, 5))
         0:       t = 17'd46080;
         1:       t = -17'sd46080;
         default: t = 17'(int'($urandom_range(0, 92160)) - 46080);
      endcase
      return {15'($urandom()), t};
   endfunction

   function automatic logic [31:0] pick_limit();
      logic [14:0] l;
      case ($urandom_range(0, 5))
         0:       l = 15'd0;
         1:       l = 15'h7fff;
         default: l = 15'($urandom());
      endcase
      return {17'($urandom()), l};
   endfunction

   task automatic randomize_settings();
      if ($urandom_range(0, 2) != 0) write_reg(REG_TARGET_ANGLE, pick_target());
      if ($urandom_range(0, 2) != 0) write_reg(REG_ANGLE_GAIN_P, pick_gain());
      if ($urandom_range(0, 2) != 0) write_reg(REG_ANGLE_GAIN_I, pick_gain());
      if ($urandom_range(0, 2) != 0) write_reg(REG_GYRO_GAIN_D, pick_gain());
      if ($urandom_range(0, 2) != 0) write_reg(REG_SPEED_GAIN_P, pick_gain());
      if ($urandom_range(0, 2) != 0) write_reg(REG_SPEED_GAIN_I, pick_gain());
      if ($urandom_range(0, 2) != 0) write_reg(REG_DUTY_LIMIT, pick_limit());
      if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, $urandom());
   endtask

   initial begin
      int t;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed checks against the reset settings.
      rsp_idle_on = 1'b1;
      t = int'(target_q8);
      queue_sample(t, 0, 0);
      queue_sample(46080, 32767, 32767);
      queue_sample(-46080, -32768, -32768);
      queue_sample(17'h0ffff, 0, 0);
      queue_sample(17'h10000, 0, 0);
      queue_sample(17'h1ffff, 1, -1);
      queue_sample(t + 1792, 0, 0);
      queue_sample(t + 1791, 0, 0);
      queue_sample(t - 1792, 0, 0);
      queue_sample(t - 1791, 0, 0);
      queue_sample(t + 2560, 0, 0);
      queue_sample(t + 2561, 0, 0);
      queue_sample(t - 2560, 0, 0);
      queue_sample(t - 2559, 0, 0);
      queue_sample(t + 1000, -32768, 0);
      queue_sample(t - 1000, 32767, 0);
      queue_sample(t + 20, 0, 32767);
      queue_sample(t - 20, 0, -32768);
      queue_sample(t + 1, 100, 16'h5555);
      queue_sample(t - 1, -100, 16'haaaa);
      wait_drained();

      // Every register at its upper extreme, then at its lower extreme.
      write_reg(REG_TARGET_ANGLE, 32'd46080);
      write_reg(REG_ANGLE_GAIN_P, 32'h7fff_ffff);
      write_reg(REG_ANGLE_GAIN_I, 32'h7fff_ffff);
      write_reg(REG_GYRO_GAIN_D, 32'h7fff_ffff);
      write_reg(REG_SPEED_GAIN_P, 32'h7fff_ffff);
      write_reg(REG_SPEED_GAIN_I, 32'h7fff_ffff);
      write_reg(REG_DUTY_LIMIT, 32'h0000_7fff);
      write_reg(REG_UNUSED, 32'hffff_ffff);
      tx_idle_on = 1'b1;
      repeat (40) queue_random_sample();
      wait_drained();

      write_reg(REG_TARGET_ANGLE, -32'sd46080);
      write_reg(REG_ANGLE_GAIN_P, 32'h8000_0000);
      write_reg(REG_ANGLE_GAIN_I, 32'h8000_0000);
      write_reg(REG_GYRO_GAIN_D, 32'h8000_0000);
      write_reg(REG_SPEED_GAIN_P, 32'h8000_0000);
      write_reg(REG_SPEED_GAIN_I, 32'h8000_0000);
      write_reg(REG_DUTY_LIMIT, 32'hffff_8000);
      repeat (40) queue_random_sample();
      wait_drained();

      for (int phase = 0; phase < 10; phase++) begin
         randomize_settings();
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         if (phase == 1) begin
            // Back-to-back beats against a long receiver hold fill the pipeline.
            tx_idle_on = 1'b0;
            repeat (PHASE_ITEMS) queue_random_sample();
            hold_ticket++;
         end else begin
            repeat (PHASE_ITEMS) queue_random_sample();
         end
         wait_drained();
      end

      // Final stretch without idling: push the speed integrator hard one way, then back.
      tx_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      write_reg(REG_DUTY_LIMIT, 32'h0000_7fff);
      write_reg(REG_SPEED_GAIN_I, 32'h8000_0000);
      repeat (RAIL_ITEMS) queue_sample(near_target_pitch(), sensor_value(), -32768);
      wait_drained();
      write_reg(REG_SPEED_GAIN_I, 32'h7fff_ffff);
      repeat (RAIL_ITEMS) queue_sample(near_target_pitch(), sensor_value(), -32768);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("tb_balance_pid_with_speed_loop: PASS");
      end else begin
         $display("tb_balance_pid_with_speed_loop: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/bpid_pkg.sv
hw/rtl/bpid_pipe.sv
hw/rtl/balance_pid_with_speed_loop.sv
tb/tb_balance_pid_with_speed_loop.sv
